// ===== src/aes_pkg.sv =====
`timescale 1ns / 1ps

package aes_pkg;

	localparam int unsigned BLOCK_W = 128;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned NUM_RK = 15;
	localparam int unsigned NUM_CELLS = 14;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_SIZE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = 3'd4;

	localparam logic [1:0] KEY_128 = 2'd0;
	localparam logic [1:0] KEY_192 = 2'd1;

	localparam logic CMD_DECRYPT = 1'b1;

	typedef struct packed {
		logic valid;
		logic cmd;
	} beat_ctl_t;

	localparam logic [7:0] SBOX_TBL [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	localparam logic [7:0] INV_SBOX_TBL [256] = '{
		8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
		8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
		8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
		8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
		8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
		8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
		8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
		8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
		8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
		8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
		8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
		8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
		8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
		8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
		8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
		8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
		8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
		8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
		8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
		8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
		8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
		8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
		8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
		8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
		8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
		8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
		8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
		8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
		8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
		8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
		8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
		8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
	};

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [WORD_W-1:0] sub_word(input logic [WORD_W-1:0] w);
		return {SBOX_TBL[w[31:24]], SBOX_TBL[w[23:16]], SBOX_TBL[w[15:8]], SBOX_TBL[w[7:0]]};
	endfunction

	function automatic logic [BLOCK_W-1:0] sub_bytes(input logic [BLOCK_W-1:0] s,
		input logic inv);
		logic [BLOCK_W-1:0] r;
		r = '0;
		for (int i = 0; i < 16; i++) begin
			r[8*i +: 8] = inv ? INV_SBOX_TBL[s[8*i +: 8]] : SBOX_TBL[s[8*i +: 8]];
		end
		return r;
	endfunction

	function automatic logic [BLOCK_W-1:0] shift_rows(input logic [BLOCK_W-1:0] s,
		input logic inv);
		logic [BLOCK_W-1:0] r;
		r = '0;
		for (int rr = 0; rr < 4; rr++) begin
			for (int c = 0; c < 4; c++) begin
				if (inv) begin
					r[BLOCK_W-8-8*(rr+4*((c+rr)%4)) +: 8] = s[BLOCK_W-8-8*(rr+4*c) +: 8];
				end else begin
					r[BLOCK_W-8-8*(rr+4*c) +: 8] = s[BLOCK_W-8-8*(rr+4*((c+rr)%4)) +: 8];
				end
			end
		end
		return r;
	endfunction

	function automatic logic [BLOCK_W-1:0] mix_columns(input logic [BLOCK_W-1:0] s,
		input logic inv);
		logic [BLOCK_W-1:0] r;
		logic [7:0] a [4];
		logic [7:0] a2 [4];
		logic [7:0] a4 [4];
		logic [7:0] a8 [4];
		logic [7:0] m1 [4];
		logic [7:0] m2 [4];
		logic [7:0] m3 [4];
		logic [7:0] m0 [4];
		r = '0;
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				a[k] = s[BLOCK_W-8-8*(4*c+k) +: 8];
				a2[k] = xt(a[k]);
				a4[k] = xt(a2[k]);
				a8[k] = xt(a4[k]);
				if (inv) begin
					m0[k] = a8[k] ^ a4[k] ^ a2[k];
					m1[k] = a8[k] ^ a2[k] ^ a[k];
					m2[k] = a8[k] ^ a4[k] ^ a[k];
					m3[k] = a8[k] ^ a[k];
				end else begin
					m0[k] = a2[k];
					m1[k] = a2[k] ^ a[k];
					m2[k] = a[k];
					m3[k] = a[k];
				end
			end
			for (int rr = 0; rr < 4; rr++) begin
				r[BLOCK_W-8-8*(4*c+rr) +: 8] = m0[rr] ^ m1[(rr+1)%4] ^ m2[(rr+2)%4]
					^ m3[(rr+3)%4];
			end
		end
		return r;
	endfunction

endpackage

// ===== src/aes_block_cipher_core.sv =====
`timescale 1ns / 1ps

// Every input beat passes the input key-add register and all 14 round cells,
// for all key sizes. Throughput: one block per cycle while the output is not
// stalled and key expansion is idle. After reset and after each key register
// write, key expansion runs one schedule word per cycle with in_ready held low.
// Reset clears the key registers and valid state; the schedule then rebuilds.
module aes_block_cipher_core (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [aes_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [63:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic command,
	input  logic [63:0] block_hi,
	input  logic [63:0] block_lo,
	output logic out_valid,
	input  logic out_ready,
	output logic [63:0] result_hi,
	output logic [63:0] result_lo
);
	import aes_pkg::*;

	logic [1:0] key_size_q;
	logic [63:0] key_word0_q;
	logic [63:0] key_word1_q;
	logic [63:0] key_word2_q;
	logic [63:0] key_word3_q;
	logic busy;
	logic [3:0] num_rounds;
	logic [BLOCK_W-1:0] round_key [NUM_RK];
	logic en;
	logic [BLOCK_W-1:0] in_block;
	logic [BLOCK_W-1:0] first_key;
	logic [BLOCK_W-1:0] last_key;
	beat_ctl_t ctl_s [NUM_CELLS+1];
	logic [BLOCK_W-1:0] data_s [NUM_CELLS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_size_q <= '0;
			key_word0_q <= '0;
			key_word1_q <= '0;
			key_word2_q <= '0;
			key_word3_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_KEY_SIZE: key_size_q <= cfg_data[1:0];
				REG_KEY_WORD0: key_word0_q <= cfg_data;
				REG_KEY_WORD1: key_word1_q <= cfg_data;
				REG_KEY_WORD2: key_word2_q <= cfg_data;
				REG_KEY_WORD3: key_word3_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	aes_key_expander u_keys (
		.clk(clk),
		.arst_n(arst_n),
		.restart(cfg_we),
		.key_size(key_size_q),
		.key_word0(key_word0_q),
		.key_word1(key_word1_q),
		.key_word2(key_word2_q),
		.key_word3(key_word3_q),
		.busy(busy),
		.num_rounds(num_rounds),
		.round_key(round_key)
	);

	assign en = !ctl_s[NUM_CELLS].valid || out_ready;
	assign in_ready = en && !busy;
	assign in_block = {block_hi, block_lo};
	assign last_key = (num_rounds == 4'd10) ? round_key[10] :
		(num_rounds == 4'd12) ? round_key[12] : round_key[14];
	assign first_key = (command == CMD_DECRYPT) ? last_key : round_key[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0].valid <= in_valid && in_ready;
			ctl_s[0].cmd <= command;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s[0] <= in_block ^ first_key;
		end
	end

	for (genvar j = 1; j <= NUM_CELLS; j++) begin : g_cell
		logic [BLOCK_W-1:0] dec_key;
		if (j <= 10) begin : g_k10
			assign dec_key = (num_rounds == 4'd10) ? round_key[10-j] :
				(num_rounds == 4'd12) ? round_key[12-j] : round_key[14-j];
		end else if (j <= 12) begin : g_k12
			assign dec_key = (num_rounds == 4'd12) ? round_key[12-j] : round_key[14-j];
		end else begin : g_k14
			assign dec_key = round_key[14-j];
		end

		aes_round_cell #(
			.ROUND(j)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.num_rounds(num_rounds),
			.enc_key(round_key[j]),
			.dec_key(dec_key),
			.ctl_in(ctl_s[j-1]),
			.data_in(data_s[j-1]),
			.ctl_q(ctl_s[j]),
			.data_q(data_s[j])
		);
	end

	assign out_valid = ctl_s[NUM_CELLS].valid;
	assign result_hi = data_s[NUM_CELLS][127:64];
	assign result_lo = data_s[NUM_CELLS][63:0];

endmodule

// ===== src/aes_round_cell.sv =====
`timescale 1ns / 1ps

module aes_round_cell #(
	parameter int unsigned ROUND = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [3:0] num_rounds,
	input  logic [aes_pkg::BLOCK_W-1:0] enc_key,
	input  logic [aes_pkg::BLOCK_W-1:0] dec_key,
	input  aes_pkg::beat_ctl_t ctl_in,
	input  logic [aes_pkg::BLOCK_W-1:0] data_in,
	output aes_pkg::beat_ctl_t ctl_q,
	output logic [aes_pkg::BLOCK_W-1:0] data_q
);
	import aes_pkg::*;

	logic active;
	logic last;
	logic [BLOCK_W-1:0] enc_a;
	logic [BLOCK_W-1:0] enc_o;
	logic [BLOCK_W-1:0] dec_b;
	logic [BLOCK_W-1:0] dec_o;
	logic [BLOCK_W-1:0] next_d;

	assign active = 4'(ROUND) <= num_rounds;
	assign last = 4'(ROUND) == num_rounds;

	assign enc_a = shift_rows(sub_bytes(data_in, 1'b0), 1'b0);
	assign enc_o = (last ? enc_a : mix_columns(enc_a, 1'b0)) ^ enc_key;
	assign dec_b = sub_bytes(shift_rows(data_in, 1'b1), 1'b1) ^ dec_key;
	assign dec_o = last ? dec_b : mix_columns(dec_b, 1'b1);
	assign next_d = !active ? data_in : (ctl_in.cmd == CMD_DECRYPT) ? dec_o : enc_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= next_d;
		end
	end

endmodule

// ===== src/aes_key_expander.sv =====
`timescale 1ns / 1ps

module aes_key_expander (
	input  logic clk,
	input  logic arst_n,
	input  logic restart,
	input  logic [1:0] key_size,
	input  logic [63:0] key_word0,
	input  logic [63:0] key_word1,
	input  logic [63:0] key_word2,
	input  logic [63:0] key_word3,
	output logic busy,
	output logic [3:0] num_rounds,
	output logic [aes_pkg::BLOCK_W-1:0] round_key [aes_pkg::NUM_RK]
);
	import aes_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_RUN = 2'd2;

	logic [1:0] state_q;
	logic [5:0] idx_q;
	logic [2:0] phase_q;
	logic [7:0] rcon_q;
	logic [WORD_W-1:0] win_q [8];
	logic [WORD_W-1:0] kw [8];
	logic [3:0] nk;
	logic [5:0] last_idx;
	logic [WORD_W-1:0] prev_w;
	logic [WORD_W-1:0] far_w;
	logic [WORD_W-1:0] t;
	logic [WORD_W-1:0] new_w;

	assign nk = (key_size == KEY_128) ? 4'd4 : (key_size == KEY_192) ? 4'd6 : 4'd8;
	assign num_rounds = nk + 4'd6;
	assign last_idx = 6'({num_rounds, 2'b00} + 6'd3);
	assign busy = state_q != ST_IDLE;

	assign kw[0] = key_word0[63:32];
	assign kw[1] = key_word0[31:0];
	assign kw[2] = key_word1[63:32];
	assign kw[3] = key_word1[31:0];
	assign kw[4] = key_word2[63:32];
	assign kw[5] = key_word2[31:0];
	assign kw[6] = key_word3[63:32];
	assign kw[7] = key_word3[31:0];

	assign prev_w = win_q[7];
	assign far_w = (nk == 4'd4) ? win_q[4] : (nk == 4'd6) ? win_q[2] : win_q[0];

	always_comb begin
		t = prev_w;
		if (phase_q == 3'd0) begin
			t = sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rcon_q, 24'h0};
		end else if (nk == 4'd8 && phase_q == 3'd4) begin
			t = sub_word(prev_w);
		end
		new_w = far_w ^ t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			idx_q <= '0;
			phase_q <= '0;
			rcon_q <= 8'h01;
		end else if (restart) begin
			state_q <= ST_LOAD;
		end else begin
			case (state_q)
				ST_LOAD: begin
					state_q <= ST_RUN;
					idx_q <= {2'b00, nk};
					phase_q <= '0;
					rcon_q <= 8'h01;
				end
				ST_RUN: begin
					if (idx_q == last_idx) begin
						state_q <= ST_IDLE;
					end
					idx_q <= idx_q + 6'd1;
					if ({1'b0, phase_q} == nk - 4'd1) begin
						phase_q <= '0;
					end else begin
						phase_q <= phase_q + 3'd1;
					end
					if (phase_q == 3'd0) begin
						rcon_q <= xt(rcon_q);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (!restart && state_q == ST_LOAD) begin
			round_key[0] <= {key_word0, key_word1};
			round_key[1] <= {key_word2, key_word3};
			for (int k = 0; k < 8; k++) begin
				if (nk == 4'd4) begin
					win_q[k] <= (k >= 4) ? kw[(k+4)%8] : '0;
				end else if (nk == 4'd6) begin
					win_q[k] <= (k >= 2) ? kw[(k+6)%8] : '0;
				end else begin
					win_q[k] <= kw[k];
				end
			end
		end else if (!restart && state_q == ST_RUN) begin
			for (int k = 0; k < 7; k++) begin
				win_q[k] <= win_q[k+1];
			end
			win_q[7] <= new_w;
			round_key[idx_q[5:2]][WORD_W*(2'd3 - idx_q[1:0]) +: WORD_W] <= new_w;
		end
	end

endmodule
